FILE: rtl/rltb_pkg.sv
package rltb_pkg;

  // Sizes
  localparam int TOKEN_DEPTH = 4096;
  localparam int STACK_DEPTH = 256;
  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int POS_W    = $clog2(TOKEN_DEPTH);
  localparam int TOTAL_W  = POS_W + 1;
  localparam int SP_W     = $clog2(STACK_DEPTH);
  localparam int LEVEL_W  = SP_W + 1;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W  = KIND_W + COUNT_BITS;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CMD_W-1:0]    cmd_t;

  // Commands
  localparam cmd_t CMD_FEED   = 2'd0;
  localparam cmd_t CMD_FINISH = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;

  // Source characters that form tokens
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_RIGHT  = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT   = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_OUTPUT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_INPUT  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h5D;

  // Token kinds
  localparam kind_t KIND_PLUS   = 3'd0;
  localparam kind_t KIND_MINUS  = 3'd1;
  localparam kind_t KIND_RIGHT  = 3'd2;
  localparam kind_t KIND_LEFT   = 3'd3;
  localparam kind_t KIND_OUTPUT = 3'd4;
  localparam kind_t KIND_INPUT  = 3'd5;
  localparam kind_t KIND_OPEN   = 3'd6;
  localparam kind_t KIND_CLOSE  = 3'd7;

  // Status codes
  localparam status_t ST_OK             = 2'd0;
  localparam status_t ST_UNMATCHED_OPEN = 2'd1;
  localparam status_t ST_UNMATCHED_CLOSE = 2'd2;
  localparam status_t ST_OVERFLOW       = 2'd3;

  // Classified work handed from front to back
  typedef enum logic [2:0] {
    OP_RUN,
    OP_SINGLE,
    OP_OPEN,
    OP_CLOSE,
    OP_FINISH,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e             op;
    kind_t           kind;
    logic [POS_W-1:0] index;
  } op_t;

  // Keep the first error only
  function automatic status_t flag_error(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

FILE: rtl/rltb_front.sv
module rltb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rltb_pkg::cmd_t              command_i,
  input  logic [rltb_pkg::BYTE_W-1:0] source_byte_i,
  input  logic [rltb_pkg::POS_W-1:0]  read_index_i,
  input  logic                        q_full_i,
  output logic                        busy_o,
  output logic                        push_o,
  output rltb_pkg::op_t               op_o
);

  logic          keep;
  rltb_pkg::op_t cls;
  logic          stage_vld_q, stage_vld_d;
  rltb_pkg::op_t stage_q, stage_d;

  // Classify the incoming item; filler bytes and unknown commands are dropped
  always_comb begin
    keep      = 1'b1;
    cls.op    = rltb_pkg::OP_RUN;
    cls.kind  = rltb_pkg::KIND_PLUS;
    cls.index = read_index_i;
    unique case (command_i)
      rltb_pkg::CMD_FEED: begin
        unique case (source_byte_i)
          rltb_pkg::CH_PLUS:  cls.kind = rltb_pkg::KIND_PLUS;
          rltb_pkg::CH_MINUS: cls.kind = rltb_pkg::KIND_MINUS;
          rltb_pkg::CH_RIGHT: cls.kind = rltb_pkg::KIND_RIGHT;
          rltb_pkg::CH_LEFT:  cls.kind = rltb_pkg::KIND_LEFT;
          rltb_pkg::CH_OUTPUT: begin
            cls.op   = rltb_pkg::OP_SINGLE;
            cls.kind = rltb_pkg::KIND_OUTPUT;
          end
          rltb_pkg::CH_INPUT: begin
            cls.op   = rltb_pkg::OP_SINGLE;
            cls.kind = rltb_pkg::KIND_INPUT;
          end
          rltb_pkg::CH_OPEN: begin
            cls.op   = rltb_pkg::OP_OPEN;
            cls.kind = rltb_pkg::KIND_OPEN;
          end
          rltb_pkg::CH_CLOSE: begin
            cls.op   = rltb_pkg::OP_CLOSE;
            cls.kind = rltb_pkg::KIND_CLOSE;
          end
          default: keep = 1'b0;
        endcase
      end
      rltb_pkg::CMD_FINISH: cls.op = rltb_pkg::OP_FINISH;
      rltb_pkg::CMD_READ:   cls.op = rltb_pkg::OP_READ;
      default:              keep = 1'b0;
    endcase
  end

  // One staging register in front of the queue
  assign busy_o = stage_vld_q & q_full_i;
  assign push_o = stage_vld_q & ~q_full_i;
  assign op_o   = stage_q;

  always_comb begin
    stage_vld_d = stage_vld_q;
    stage_d     = stage_q;
    if (start_i && !busy_o) begin
      stage_vld_d = keep;
      stage_d     = cls;
    end else if (push_o) begin
      stage_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

endmodule

FILE: rtl/rltb_queue.sv
module rltb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rltb_pkg::op_t op_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output rltb_pkg::op_t op_o
);

  rltb_pkg::op_t                   slot_q [rltb_pkg::QUEUE_DEPTH];
  logic [rltb_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rltb_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == rltb_pkg::QCNT_W'(rltb_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == rltb_pkg::QPTR_W'(rltb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == rltb_pkg::QPTR_W'(rltb_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Item slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

FILE: rtl/rltb_back.sv
module rltb_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  rltb_pkg::op_t                   q_op_i,
  output logic                            pop_o,
  output logic                            done_o,
  output rltb_pkg::kind_t                 token_kind_o,
  output logic [rltb_pkg::COUNT_BITS-1:0] token_value_o,
  output logic [rltb_pkg::TOTAL_W-1:0]    token_total_o,
  output rltb_pkg::status_t               status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_CLOSE,
    S_READ
  } state_e;

  state_e                            state_q, state_d;
  rltb_pkg::op_t                     op_q, op_d;
  logic [rltb_pkg::TOTAL_W-1:0]      wp_q, wp_d;
  logic [rltb_pkg::LEVEL_W-1:0]      level_q, level_d;
  rltb_pkg::kind_t                   pend_q, pend_d;
  logic [rltb_pkg::COUNT_BITS-1:0]   run_q, run_d;
  rltb_pkg::status_t                 err_q, err_d;
  logic                              hit_q, hit_d;
  logic [rltb_pkg::POS_W-1:0]        dist_q, dist_d;
  logic                              done_q, done_d;
  rltb_pkg::kind_t                   kind_q, kind_d;
  logic [rltb_pkg::COUNT_BITS-1:0]   value_q, value_d;
  logic [rltb_pkg::TOTAL_W-1:0]      total_q, total_d;
  rltb_pkg::status_t                 status_q, status_d;

  // Token store and bracket stack
  logic [rltb_pkg::ENTRY_W-1:0]      tok_mem [rltb_pkg::TOKEN_DEPTH];
  logic                              tok_we, tok_re;
  logic [rltb_pkg::POS_W-1:0]        tok_waddr;
  logic [rltb_pkg::ENTRY_W-1:0]      tok_wdata, tok_rdata_q;
  logic [rltb_pkg::POS_W-1:0]        stk_mem [rltb_pkg::STACK_DEPTH];
  logic                              stk_we, stk_re;
  logic [rltb_pkg::SP_W-1:0]         stk_raddr;
  logic [rltb_pkg::POS_W-1:0]        stk_rdata_q;

  logic                              full;
  logic                              run_match;
  logic [rltb_pkg::POS_W-1:0]        wpos;

  assign wpos      = wp_q[rltb_pkg::POS_W-1:0];
  assign full      = (wp_q == rltb_pkg::TOTAL_W'(rltb_pkg::TOKEN_DEPTH));
  assign run_match = (pend_q == rltb_pkg::kind_t'(q_op_i.kind + 3'd1)) && (run_q != '1);
  assign stk_raddr = rltb_pkg::SP_W'(level_q - 1'b1);
  assign pop_o     = (state_q == S_IDLE) && q_valid_i;

  // Sequencer: at most one token store write per cycle
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    wp_d      = wp_q;
    level_d   = level_q;
    pend_d    = pend_q;
    run_d     = run_q;
    err_d     = err_q;
    hit_d     = hit_q;
    dist_d    = dist_q;
    done_d    = 1'b0;
    kind_d    = kind_q;
    value_d   = value_q;
    total_d   = total_q;
    status_d  = status_q;
    tok_we    = 1'b0;
    tok_re    = 1'b0;
    tok_waddr = wpos;
    tok_wdata = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          op_d = q_op_i;
          case (q_op_i.op)
            rltb_pkg::OP_RUN: begin
              if (run_match) begin
                run_d = run_q + 1'b1;
              end else begin
                if (pend_q != '0) begin
                  if (full) begin
                    err_d = rltb_pkg::flag_error(err_q, rltb_pkg::ST_OVERFLOW);
                  end else begin
                    tok_we    = 1'b1;
                    tok_wdata = {rltb_pkg::kind_t'(pend_q - 1'b1), run_q};
                    wp_d      = wp_q + 1'b1;
                  end
                end
                pend_d = rltb_pkg::kind_t'(q_op_i.kind + 3'd1);
                run_d  = rltb_pkg::COUNT_BITS'(1);
              end
            end
            rltb_pkg::OP_READ: begin
              tok_re  = 1'b1;
              hit_d   = ({1'b0, q_op_i.index} < wp_q);
              state_d = S_READ;
            end
            default: begin
              // flush the pending run before the token itself
              if (pend_q != '0) begin
                if (full) begin
                  err_d = rltb_pkg::flag_error(err_q, rltb_pkg::ST_OVERFLOW);
                end else begin
                  tok_we    = 1'b1;
                  tok_wdata = {rltb_pkg::kind_t'(pend_q - 1'b1), run_q};
                  wp_d      = wp_q + 1'b1;
                end
              end
              pend_d  = '0;
              run_d   = '0;
              state_d = S_EXEC;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (op_q.op)
          rltb_pkg::OP_SINGLE: begin
            if (full) begin
              err_d = rltb_pkg::flag_error(err_q, rltb_pkg::ST_OVERFLOW);
            end else begin
              tok_we    = 1'b1;
              tok_wdata = {op_q.kind, rltb_pkg::COUNT_BITS'(1)};
              wp_d      = wp_q + 1'b1;
            end
          end
          rltb_pkg::OP_OPEN: begin
            if (full) begin
              err_d = rltb_pkg::flag_error(err_q, rltb_pkg::ST_OVERFLOW);
            end else begin
              tok_we = 1'b1;
              wp_d   = wp_q + 1'b1;
              if (level_q != rltb_pkg::LEVEL_W'(rltb_pkg::STACK_DEPTH)) begin
                tok_wdata = {rltb_pkg::KIND_OPEN, rltb_pkg::COUNT_BITS'(1)};
                stk_we    = 1'b1;
                level_d   = level_q + 1'b1;
              end else begin
                // nesting too deep: stored with zero distance, not pushed
                tok_wdata = {rltb_pkg::KIND_OPEN, rltb_pkg::COUNT_BITS'(0)};
                err_d     = rltb_pkg::flag_error(err_q, rltb_pkg::ST_UNMATCHED_OPEN);
              end
            end
          end
          rltb_pkg::OP_CLOSE: begin
            if (full) begin
              err_d = rltb_pkg::flag_error(err_q, rltb_pkg::ST_OVERFLOW);
            end else if (level_q == '0) begin
              tok_we    = 1'b1;
              tok_wdata = {rltb_pkg::KIND_CLOSE, rltb_pkg::COUNT_BITS'(0)};
              wp_d      = wp_q + 1'b1;
              err_d     = rltb_pkg::flag_error(err_q, rltb_pkg::ST_UNMATCHED_CLOSE);
            end else begin
              stk_re  = 1'b1;
              level_d = level_q - 1'b1;
              state_d = S_POP;
            end
          end
          rltb_pkg::OP_FINISH: begin
            if (level_q != '0) begin
              err_d = rltb_pkg::flag_error(err_q, rltb_pkg::ST_UNMATCHED_OPEN);
            end
            done_d   = 1'b1;
            kind_d   = rltb_pkg::KIND_PLUS;
            value_d  = '0;
            total_d  = wp_q;
            status_d = (level_q != '0) ?
                       rltb_pkg::flag_error(err_q, rltb_pkg::ST_UNMATCHED_OPEN) : err_q;
          end
          default: ;
        endcase
      end
      S_POP: begin
        // patch the open bracket with the distance
        dist_d    = wpos - stk_rdata_q;
        tok_we    = 1'b1;
        tok_waddr = stk_rdata_q;
        tok_wdata = {rltb_pkg::KIND_OPEN, rltb_pkg::COUNT_BITS'(dist_d)};
        state_d   = S_CLOSE;
      end
      S_CLOSE: begin
        tok_we    = 1'b1;
        tok_wdata = {rltb_pkg::KIND_CLOSE, rltb_pkg::COUNT_BITS'(dist_q)};
        wp_d      = wp_q + 1'b1;
        state_d   = S_IDLE;
      end
      S_READ: begin
        done_d   = 1'b1;
        kind_d   = hit_q ? tok_rdata_q[rltb_pkg::ENTRY_W-1 -: rltb_pkg::KIND_W] :
                           rltb_pkg::KIND_PLUS;
        value_d  = hit_q ? tok_rdata_q[rltb_pkg::COUNT_BITS-1:0] : '0;
        total_d  = wp_q;
        status_d = err_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      level_q <= '0;
      pend_q  <= '0;
      run_q   <= '0;
      err_q   <= rltb_pkg::ST_OK;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      level_q <= level_d;
      pend_q  <= pend_d;
      run_q   <= run_d;
      err_q   <= err_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    hit_q    <= hit_d;
    dist_q   <= dist_d;
    kind_q   <= kind_d;
    value_q  <= value_d;
    total_q  <= total_d;
    status_q <= status_d;
  end

  // Token store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tok_we) begin
      tok_mem[tok_waddr] <= tok_wdata;
    end
    if (tok_re) begin
      tok_rdata_q <= tok_mem[q_op_i.index];
    end
  end

  // Bracket stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[level_q[rltb_pkg::SP_W-1:0]] <= wpos;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  assign done_o        = done_q;
  assign token_kind_o  = kind_q;
  assign token_value_o = value_q;
  assign token_total_o = total_q;
  assign status_o      = status_q;

  // Checks
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= rltb_pkg::TOTAL_W'(rltb_pkg::TOKEN_DEPTH))
    else $error("write position past store depth");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != rltb_pkg::ST_OK) |=> (err_q == $past(err_q)))
    else $error("error code changed after first error");

  a_pop_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> ($past(state_q) == S_EXEC))
    else $error("stack pop outside close bracket");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_READ || $past(state_q) == S_EXEC))
    else $error("result without finish or read");

  a_pend_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> (run_q != '0))
    else $error("pending run with zero count");

endmodule

FILE: rtl/run_length_tokenizer_bracket_match.sv
// Channel   Direction  Handshake                 Payload
// command   in         start_i & !busy_o         command_i, source_byte_i, read_index_i
// result    out        done_o (one cycle)        token_kind_o, token_value_o,
//                                                token_total_o, status_o
//
// A front stage classifies each item and parks it in a two-entry queue; the back
// sequencer runs it on the token store (one write and one read port) in states: run
// character IDLE; '.' ',' '[' finish IDLE, EXEC; read IDLE, READ; matched ']' IDLE,
// EXEC (stack read), POP, CLOSE (two store writes); the result registers from the last.
// busy_o rises only while the staging register and queue are both full.
// Reset clears all control state; store and stack contents are undefined until written.
// Results cannot be held off: done_o pulses for one cycle per finish or read.
module run_length_tokenizer_bracket_match (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  rltb_pkg::cmd_t                  command_i,
  input  logic [rltb_pkg::BYTE_W-1:0]     source_byte_i,
  input  logic [rltb_pkg::POS_W-1:0]      read_index_i,
  output logic                            done_o,
  output rltb_pkg::kind_t                 token_kind_o,
  output logic [rltb_pkg::COUNT_BITS-1:0] token_value_o,
  output logic [rltb_pkg::TOTAL_W-1:0]    token_total_o,
  output rltb_pkg::status_t               status_o
);

  logic          q_full, q_push, q_valid, q_pop;
  rltb_pkg::op_t f_op, q_op;

  rltb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .command_i     (command_i),
    .source_byte_i (source_byte_i),
    .read_index_i  (read_index_i),
    .q_full_i      (q_full),
    .busy_o        (busy_o),
    .push_o        (q_push),
    .op_o          (f_op)
  );

  rltb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (f_op),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  rltb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_op_i        (q_op),
    .pop_o         (q_pop),
    .done_o        (done_o),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .token_total_o (token_total_o),
    .status_o      (status_o)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

// Command code the block ignores
localparam rltb_pkg::cmd_t CMD_UNUSED = 2'd3;

localparam int unsigned COUNT_MAX = (1 << rltb_pkg::COUNT_BITS) - 1;

typedef struct {
  rltb_pkg::kind_t                 kind;
  logic [rltb_pkg::COUNT_BITS-1:0] value;
  logic [rltb_pkg::TOTAL_W-1:0]    total;
  rltb_pkg::status_t               status;
} token_reply_t;

// Tracks the token store, bracket stack and pending run; holds the replies still owed
class token_scoreboard;
  rltb_pkg::kind_t                 tok_kind  [rltb_pkg::TOKEN_DEPTH];
  logic [rltb_pkg::COUNT_BITS-1:0] tok_value [rltb_pkg::TOKEN_DEPTH];
  int unsigned                     open_pos  [rltb_pkg::STACK_DEPTH];
  int unsigned                     level;
  int unsigned                     wpos;
  int unsigned                     run_len;
  int unsigned                     pend;     // 0: no run, else kind + 1
  rltb_pkg::status_t               err;
  token_reply_t                    awaited [$];
  int                              errors;

  function new();
    level   = 0;
    wpos    = 0;
    run_len = 0;
    pend    = 0;
    err     = rltb_pkg::ST_OK;
    errors  = 0;
  endfunction

  // First error sticks
  function void raise(rltb_pkg::status_t code);
    if (err == rltb_pkg::ST_OK) err = code;
  endfunction

  function bit store_token(rltb_pkg::kind_t k, logic [rltb_pkg::COUNT_BITS-1:0] v);
    if (wpos >= rltb_pkg::TOKEN_DEPTH) begin
      raise(rltb_pkg::ST_OVERFLOW);
      return 1'b0;
    end
    tok_kind[wpos]  = k;
    tok_value[wpos] = v;
    wpos++;
    return 1'b1;
  endfunction

  function void flush_run();
    if (pend != 0) begin
      void'(store_token(rltb_pkg::kind_t'(pend - 1), rltb_pkg::COUNT_BITS'(run_len)));
    end
    pend    = 0;
    run_len = 0;
  endfunction

  function void take_byte(logic [7:0] b);
    rltb_pkg::kind_t k;
    int unsigned     p;
    int unsigned     span;
    case (b)
      rltb_pkg::CH_PLUS:   k = rltb_pkg::KIND_PLUS;
      rltb_pkg::CH_MINUS:  k = rltb_pkg::KIND_MINUS;
      rltb_pkg::CH_RIGHT:  k = rltb_pkg::KIND_RIGHT;
      rltb_pkg::CH_LEFT:   k = rltb_pkg::KIND_LEFT;
      rltb_pkg::CH_OUTPUT: k = rltb_pkg::KIND_OUTPUT;
      rltb_pkg::CH_INPUT:  k = rltb_pkg::KIND_INPUT;
      rltb_pkg::CH_OPEN:   k = rltb_pkg::KIND_OPEN;
      rltb_pkg::CH_CLOSE:  k = rltb_pkg::KIND_CLOSE;
      default:             return;
    endcase
    // run characters extend the pending run until the count limit
    if (k <= rltb_pkg::KIND_LEFT) begin
      if (pend == int'(k) + 1 && run_len < COUNT_MAX) begin
        run_len++;
        return;
      end
      flush_run();
      pend    = int'(k) + 1;
      run_len = 1;
      return;
    end
    flush_run();
    p = wpos;
    if (k == rltb_pkg::KIND_OPEN) begin
      if (!store_token(rltb_pkg::KIND_OPEN, rltb_pkg::COUNT_BITS'(1))) return;
      if (level < rltb_pkg::STACK_DEPTH) begin
        open_pos[level] = p;
        level++;
      end else begin
        tok_value[p] = '0;
        raise(rltb_pkg::ST_UNMATCHED_OPEN);
      end
    end else if (k == rltb_pkg::KIND_CLOSE) begin
      if (!store_token(rltb_pkg::KIND_CLOSE, rltb_pkg::COUNT_BITS'(1))) return;
      if (level == 0) begin
        tok_value[p] = '0;
        raise(rltb_pkg::ST_UNMATCHED_CLOSE);
      end else begin
        level--;
        span = p - open_pos[level];
        tok_value[open_pos[level]] = rltb_pkg::COUNT_BITS'(span);
        tok_value[p]               = rltb_pkg::COUNT_BITS'(span);
      end
    end else begin
      void'(store_token(k, rltb_pkg::COUNT_BITS'(1)));
    end
  endfunction

  // Called for each accepted item
  function void note_item(rltb_pkg::cmd_t cmd, logic [7:0] b,
                          logic [rltb_pkg::POS_W-1:0] idx);
    token_reply_t r;
    r.kind  = rltb_pkg::KIND_PLUS;
    r.value = '0;
    case (cmd)
      rltb_pkg::CMD_FEED: begin
        take_byte(b);
        return;
      end
      rltb_pkg::CMD_FINISH: begin
        flush_run();
        if (level != 0) raise(rltb_pkg::ST_UNMATCHED_OPEN);
      end
      rltb_pkg::CMD_READ: begin
        if (idx < wpos) begin
          r.kind  = tok_kind[idx];
          r.value = tok_value[idx];
        end
      end
      default: return;
    endcase
    r.total  = rltb_pkg::TOTAL_W'(wpos);
    r.status = err;
    awaited.push_back(r);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (errors < 40)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(rltb_pkg::kind_t k, logic [rltb_pkg::COUNT_BITS-1:0] v,
                             logic [rltb_pkg::TOTAL_W-1:0] t, rltb_pkg::status_t s);
    token_reply_t r;
    if (awaited.size() == 0) begin
      if (errors < 40)
        $display("%0t ns: unexpected result, expected none, actual kind=%0d value=%0d",
                 $time, k, v);
      errors++;
      return;
    end
    r = awaited.pop_front();
    compare_field("token_kind", 32'(r.kind), 32'(k));
    compare_field("token_value", 32'(r.value), 32'(v));
    compare_field("token_total", 32'(r.total), 32'(t));
    compare_field("status", 32'(r.status), 32'(s));
  endfunction
endclass

module tb;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  rltb_pkg::cmd_t                  command_i;
  logic [rltb_pkg::BYTE_W-1:0]     source_byte_i;
  logic [rltb_pkg::POS_W-1:0]      read_index_i;
  logic                            done_o;
  rltb_pkg::kind_t                 token_kind_o;
  logic [rltb_pkg::COUNT_BITS-1:0] token_value_o;
  logic [rltb_pkg::TOTAL_W-1:0]    token_total_o;
  rltb_pkg::status_t               status_o;

  token_scoreboard sb;
  int              idle_rate;
  logic [7:0]      last_run_char = rltb_pkg::CH_PLUS;

  run_length_tokenizer_bracket_match dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .source_byte_i (source_byte_i),
    .read_index_i  (read_index_i),
    .done_o        (done_o),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .token_total_o (token_total_o),
    .status_o      (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        sb.check_result(token_kind_o, token_value_o, token_total_o, status_o);
      end else if (done_o !== 1'b0) begin
        $display("%0t ns: done_o mismatch, expected 0 or 1, actual %b", $time, done_o);
        sb.errors++;
      end
    end
  end

  // Drive one item, with an optional idle burst ahead of it; returns at a falling edge
  task automatic send_item(rltb_pkg::cmd_t c, logic [7:0] b,
                           logic [rltb_pkg::POS_W-1:0] idx);
    if (idle_rate != 0 && $urandom_range(0, 3) < idle_rate) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i       <= 1'b1;
    command_i     <= c;
    source_byte_i <= b;
    read_index_i  <= idx;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_item(c, b, idx);
    @(negedge clk_i);
  endtask

  task automatic feed_char(logic [7:0] b);
    send_item(rltb_pkg::CMD_FEED, b, rltb_pkg::POS_W'($urandom));
  endtask

  task automatic ask_token(logic [rltb_pkg::POS_W-1:0] idx);
    send_item(rltb_pkg::CMD_READ, 8'($urandom), idx);
  endtask

  task automatic finish_program();
    send_item(rltb_pkg::CMD_FINISH, 8'($urandom), rltb_pkg::POS_W'($urandom));
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b inside {rltb_pkg::CH_PLUS, rltb_pkg::CH_MINUS, rltb_pkg::CH_RIGHT,
                     rltb_pkg::CH_LEFT, rltb_pkg::CH_OUTPUT, rltb_pkg::CH_INPUT,
                     rltb_pkg::CH_OPEN, rltb_pkg::CH_CLOSE});
    return b;
  endfunction

  // Mostly well-formed program text: runs, singles, shallow nesting, some noise
  function automatic logic [7:0] random_source_byte(int unsigned depth);
    logic [7:0] runs [4] = '{rltb_pkg::CH_PLUS, rltb_pkg::CH_MINUS,
                             rltb_pkg::CH_RIGHT, rltb_pkg::CH_LEFT};
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return last_run_char;
    if (pick < 55) begin
      last_run_char = runs[$urandom_range(0, 3)];
      return last_run_char;
    end
    if (pick < 65) return ($urandom_range(0, 1) != 0) ? rltb_pkg::CH_OUTPUT :
                                                        rltb_pkg::CH_INPUT;
    if (pick < 77) return (depth < 24) ? rltb_pkg::CH_OPEN : rltb_pkg::CH_CLOSE;
    if (pick < 89) return (depth > 0) ? rltb_pkg::CH_CLOSE : rltb_pkg::CH_OPEN;
    return noise_byte();
  endfunction

  initial begin
    string       prog;
    int          pick;
    int unsigned base;
    int          waited;
    sb            = new();
    idle_rate     = 1;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    command_i     = rltb_pkg::CMD_FEED;
    source_byte_i = '0;
    read_index_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: empty store, runs broken only by command chars, every kind, nesting
    ask_token('0);
    finish_program();
    feed_char(rltb_pkg::CH_PLUS);
    feed_char(rltb_pkg::CH_PLUS);
    feed_char(8'h00);
    feed_char(rltb_pkg::CH_PLUS);
    feed_char(8'hFF);
    prog = "->><.,[>[.]]";
    for (int i = 0; i < prog.len(); i++) feed_char(prog[i]);
    finish_program();
    for (int i = 0; i < sb.wpos; i++) ask_token(rltb_pkg::POS_W'(i));
    ask_token('1);
    send_item(CMD_UNUSED, 8'($urandom), rltb_pkg::POS_W'($urandom));
    // feeding after finish continues the same program
    feed_char(rltb_pkg::CH_PLUS);
    finish_program();

    // Random well-formed programs with reads, finishes and unused commands mixed in
    for (int n = 0; n < 220; n++) begin
      if (n % 60 == 0) idle_rate = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        feed_char(random_source_byte(sb.level));
      end else if (pick < 82) begin
        if (sb.wpos > 0 && pick < 78) begin
          ask_token(rltb_pkg::POS_W'($urandom_range(0, sb.wpos - 1)));
        end else begin
          ask_token(rltb_pkg::POS_W'($urandom));
        end
      end else if (pick < 92) begin
        if (sb.level == 0) finish_program();
        else feed_char(rltb_pkg::CH_CLOSE);
      end else begin
        send_item(CMD_UNUSED, 8'($urandom), rltb_pkg::POS_W'($urandom));
      end
    end
    while (sb.level > 0) feed_char(rltb_pkg::CH_CLOSE);
    finish_program();

    // Open bracket left at finish
    idle_rate = 1;
    feed_char(rltb_pkg::CH_OPEN);
    finish_program();
    feed_char(rltb_pkg::CH_CLOSE);

    // Nesting past the stack depth, then closes beyond the opens; no idling here
    idle_rate = 0;
    base = sb.wpos;
    for (int n = 0; n < rltb_pkg::STACK_DEPTH + 2; n++) feed_char(rltb_pkg::CH_OPEN);
    for (int n = 0; n < rltb_pkg::STACK_DEPTH + 3; n++) feed_char(rltb_pkg::CH_CLOSE);
    finish_program();
    ask_token(rltb_pkg::POS_W'(base));
    ask_token(rltb_pkg::POS_W'(base + rltb_pkg::STACK_DEPTH - 1));
    ask_token(rltb_pkg::POS_W'(base + rltb_pkg::STACK_DEPTH));
    ask_token(rltb_pkg::POS_W'(sb.wpos - 1));
    for (int n = 0; n < 10; n++) begin
      ask_token(rltb_pkg::POS_W'($urandom_range(base, sb.wpos - 1)));
    end

    // Drain outstanding results
    start_i <= 1'b0;
    for (waited = 0; waited < 1000 && sb.awaited.size() > 0; waited++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.awaited.size() != 0) begin
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5000000;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rltb_pkg.sv
rtl/rltb_front.sv
rtl/rltb_queue.sv
rtl/rltb_back.sv
rtl/run_length_tokenizer_bracket_match.sv
tb/sv/tb.sv
